// ===== design/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants
// Field widths, register indexes and the item record passed between stages.
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int CoordW = 32;
	localparam int CoefW  = 16;
	localparam int RowW   = 64;
	localparam int SumW   = 52;
	localparam int MagW   = 50;
	localparam int NumW   = 66;
	localparam int QW     = 38;

	typedef enum logic [1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2,
		REG_ROW3 = 2'd3
	} reg_idx_t;

	// Action the back end takes for one item.
	typedef enum logic [1:0] {
		ACT_SHIFT = 2'd0,
		ACT_DIV   = 2'd1,
		ACT_ZERO  = 2'd2
	} act_t;

	typedef struct packed {
		act_t                       act;
		logic signed [SumW-1:0]     sx;
		logic signed [SumW-1:0]     sy;
		logic signed [SumW-1:0]     sz;
		logic signed [SumW-1:0]     w;
	} item_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
		logic                     sat;
		logic                     zw;
	} res_t;

	function automatic logic signed [CoefW-1:0] coef(input logic [RowW-1:0] r,
			input logic [1:0] j);
		coef = r[16*j +: 16];
	endfunction

	function automatic logic [MagW-1:0] mag(input logic signed [SumW-1:0] v);
		logic [SumW-1:0] a;
		a = v[SumW-1] ? -v : v;
		mag = a[MagW-1:0];
	endfunction

	// Clamp sign and magnitude to signed 32 bits.
	function automatic logic [CoordW:0] clampo(input logic neg, input logic [QW-1:0] m);
		logic [QW-1:0] lim;
		logic [QW-1:0] mm;
		logic          s;
		lim = neg ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
		s   = m > lim;
		mm  = s ? lim : m;
		clampo = {s, neg ? -mm[CoordW-1:0] : mm[CoordW-1:0]};
	endfunction

endpackage

// ===== design/hpt_front.sv =====
// ----------------------------------------------------------------------------
// hpt_front: matrix products and classification
// Two stages: twelve products, then row sums and the choice of action.
// ----------------------------------------------------------------------------
module hpt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic signed [31:0]           in_x,
	input  logic signed [31:0]           in_y,
	input  logic signed [31:0]           in_z,
	input  logic [63:0]                  row0,
	input  logic [63:0]                  row1,
	input  logic [63:0]                  row2,
	input  logic [63:0]                  row3,
	output logic                         fv,
	input  logic                         fstall,
	output hpt_pkg::item_t               fitem
);
	import hpt_pkg::*;

	logic              v_s1, v_s2;
	logic              vec_s1;
	logic signed [47:0] p_s1 [4][3];
	logic signed [SumW-1:0] t_s1 [4];
	logic [RowW-1:0]   rows [4];
	logic              adv;
	item_t             it_s2;
	logic signed [SumW-1:0] sm [4];

	function automatic item_t fitem_next();
		item_t t;
		t.sx = sm[0];
		t.sy = sm[1];
		t.sz = sm[2];
		t.w  = sm[3];
		if (vec_s1 || sm[3] == SumW'(64'sh1000_0000)) t.act = ACT_SHIFT;
		else if (sm[3] == '0)                           t.act = ACT_ZERO;
		else                                            t.act = ACT_DIV;
		return t;
	endfunction

	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row2;
	assign rows[3] = row3;
	assign adv      = !(v_s2 && fstall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1 <= kind;
			for (int r = 0; r < 4; r++) begin
				p_s1[r][0] <= 48'(coef(rows[r], 2'd0)) * 48'(in_x);
				p_s1[r][1] <= 48'(coef(rows[r], 2'd1)) * 48'(in_y);
				p_s1[r][2] <= 48'(coef(rows[r], 2'd2)) * 48'(in_z);
				t_s1[r]    <= kind ? '0 : SumW'(coef(rows[r], 2'd3)) <<< 16;
			end
			it_s2 <= fitem_next();
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++)
			sm[r] = SumW'(p_s1[r][0]) + SumW'(p_s1[r][1]) + SumW'(p_s1[r][2]) + t_s1[r];
	end

	assign fv    = v_s2;
	assign fitem = it_s2;
endmodule

// ===== design/hpt_queue.sv =====
// ----------------------------------------------------------------------------
// hpt_queue: short queue between front and back
// Two-entry FIFO; full only blocks the front.
// ----------------------------------------------------------------------------
module hpt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wv,
	output logic           wstall,
	input  hpt_pkg::item_t wd,
	output logic           rv,
	input  logic           rstall,
	output hpt_pkg::item_t rd
);
	import hpt_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rdo;

	assign wstall = cnt_q == 2'd2;
	assign rv     = cnt_q != 2'd0;
	assign wr     = wv && !wstall;
	assign rdo    = rv && !rstall;
	assign rd     = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)  wp_q <= !wp_q;
			if (rdo) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rdo);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wd;
	end
endmodule

// ===== design/hpt_back.sv =====
// ----------------------------------------------------------------------------
// hpt_back: rounding, divide and saturation
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
module hpt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           bv,
	output logic           bstall,
	input  hpt_pkg::item_t bitem,
	output logic           out_valid,
	input  logic           out_stall,
	output hpt_pkg::res_t  res
);
	import hpt_pkg::*;

	// Quotient bits resolved; any larger quotient saturates anyway.
	localparam int QB    = 33;
	localparam int Depth = QB + 1;

	// Lane state: partial remainder, numerator, quotient so far, overflow.
	logic [MagW-1:0] rem_s  [Depth+1][3];
	logic [NumW-1:0] num_s  [Depth+1][3];
	logic [QW-1:0]   q_s    [Depth+1][3];
	logic            neg_s  [Depth+1][3];
	logic            ovf_s  [Depth+1][3];
	logic [MagW-1:0] d_s    [Depth+1];
	act_t            act_s  [Depth+1];
	logic            v_s    [Depth+1];
	logic            adv;
	logic [MagW-1:0] dm;
	logic [MagW-1:0] sm [3];
	logic [NumW-1:0] n0 [3];
	logic signed [SumW-1:0] ss [3];
	logic [CoordW:0] cl [3];
	logic [QW-1:0]   qf [3];
	res_t            rn;

	assign adv    = !(v_s[Depth] && out_stall);
	assign bstall = !adv;
	assign ss[0]  = bitem.sx;
	assign ss[1]  = bitem.sy;
	assign ss[2]  = bitem.sz;
	assign dm     = mag(bitem.w);

	// The divide path loads (mag<<16) + d/2; the shift path loads mag+2048.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sm[l] = mag(ss[l]);
			if (bitem.act == ACT_DIV)
				n0[l] = (NumW'(sm[l]) << 16) + NumW'(dm >> 1);
			else
				n0[l] = NumW'(sm[l]) + NumW'(2048);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Depth; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= bv;
			for (int k = 1; k <= Depth; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0]   <= dm;
			act_s[0] <= bitem.act;
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= '0;
				q_s[0][l]   <= '0;
				ovf_s[0][l] <= 1'b0;
				num_s[0][l] <= n0[l];
				if (bitem.act == ACT_DIV)
					neg_s[0][l] <= ss[l][SumW-1] ^ bitem.w[SumW-1];
				else
					neg_s[0][l] <= ss[l][SumW-1];
			end
			// The numerator bits above the quotient width seed the remainder; if they
			// already reach the divisor, the quotient is too large for the output.
			d_s[1]   <= d_s[0];
			act_s[1] <= act_s[0];
			for (int l = 0; l < 3; l++) begin
				neg_s[1][l] <= neg_s[0][l];
				num_s[1][l] <= num_s[0][l];
				q_s[1][l]   <= q_s[0][l];
				rem_s[1][l] <= MagW'(num_s[0][l] >> QB);
				ovf_s[1][l] <= (num_s[0][l] >> QB) >= NumW'(d_s[0]);
			end
			for (int k = 2; k <= Depth; k++) begin
				d_s[k]   <= d_s[k-1];
				act_s[k] <= act_s[k-1];
				for (int l = 0; l < 3; l++) begin
					neg_s[k][l] <= neg_s[k-1][l];
					num_s[k][l] <= num_s[k-1][l];
					ovf_s[k][l] <= ovf_s[k-1][l];
					if ({rem_s[k-1][l], num_s[k-1][l][Depth-k]} >= {1'b0, d_s[k-1]}) begin
						rem_s[k][l] <= MagW'({rem_s[k-1][l], num_s[k-1][l][Depth-k]}
							- {1'b0, d_s[k-1]});
						q_s[k][l]   <= {q_s[k-1][l][QW-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= rem_s[k-1][l][MagW-2:0] == rem_s[k-1][l][MagW-2:0]
							? {rem_s[k-1][l][MagW-2:0], num_s[k-1][l][Depth-k]}
							: {rem_s[k-1][l][MagW-2:0], num_s[k-1][l][Depth-k]};
						q_s[k][l]   <= {q_s[k-1][l][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (act_s[Depth] == ACT_DIV)
				qf[l] = ovf_s[Depth][l] ? '1 : q_s[Depth][l];
			else
				qf[l] = QW'(num_s[Depth][l] >> 12);
			cl[l] = clampo(neg_s[Depth][l], qf[l]);
		end
		rn.x   = cl[0][CoordW-1:0];
		rn.y   = cl[1][CoordW-1:0];
		rn.z   = cl[2][CoordW-1:0];
		rn.sat = cl[0][CoordW] | cl[1][CoordW] | cl[2][CoordW];
		rn.zw  = 1'b0;
		if (act_s[Depth] == ACT_ZERO) begin
			rn = '0;
			rn.zw = 1'b1;
		end
	end

	assign out_valid = v_s[Depth];
	assign res       = rn;
endmodule

// ===== design/homogeneous_point_transform_3d.sv =====
// ----------------------------------------------------------------------------
// homogeneous_point_transform_3d: 4x4 fixed-point transform with divide
// Applies a programmable matrix to Q16.16 points or direction vectors.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall with kind, in_x, in_y, in_z. One
// result leaves per item on out_valid/out_stall, in order. The matrix rows
// are written over the APB port at byte addresses 0, 8, 16 and 24. The user
// must write them only while the block is idle; the block does not enforce it.
// Throughput is one transfer per cycle while the output is not stalled. An
// input transfer passes through two front stages for the twelve 16x32
// products and row sums, the two-entry queue, and a 35-stage back pipeline:
// operand load, an overflow check on the high numerator bits, then a
// restoring divider that resolves one quotient bit per stage in each of
// three lanes.
// Reset loads the identity matrix and empties every stage. When the output
// is stalled the back pipeline freezes, the queue fills, and then the front
// stalls the input; no transfer is lost.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_3d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               saturated,
	output logic               zero_w,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import hpt_pkg::*;

	logic [63:0]   row_q [4];
	logic          fv, fstall, qv, qstall;
	item_t         fitem, qitem;
	res_t          res;
	reg_idx_t      ridx;
	logic          wen;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[4:3]);
	assign wen    = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 64'd4096;
			row_q[1] <= 64'd4096 << 16;
			row_q[2] <= 64'd4096 << 32;
			row_q[3] <= 64'd4096 << 48;
		end else if (wen) begin
			unique case (ridx)
				REG_ROW0: row_q[0] <= pwdata;
				REG_ROW1: row_q[1] <= pwdata;
				REG_ROW2: row_q[2] <= pwdata;
				REG_ROW3: row_q[3] <= pwdata;
				default:  ;
			endcase
		end
	end

	assign prdata = paddr[2:0] == 3'd0 ? row_q[paddr[4:3]] : '0;

	hpt_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .in_x, .in_y, .in_z,
		.row0(row_q[0]), .row1(row_q[1]), .row2(row_q[2]), .row3(row_q[3]),
		.fv, .fstall, .fitem
	);

	hpt_queue u_queue (
		.clk, .arst_n, .wv(fv), .wstall(fstall), .wd(fitem),
		.rv(qv), .rstall(qstall), .rd(qitem)
	);

	hpt_back u_back (
		.clk, .arst_n, .bv(qv), .bstall(qstall), .bitem(qitem),
		.out_valid, .out_stall, .res
	);

	assign out_x     = res.x;
	assign out_y     = res.y;
	assign out_z     = res.z;
	assign saturated = res.sat;
	assign zero_w    = res.zw;

	a_zw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_w |-> out_x == 0 && out_y == 0 && out_z == 0 && !saturated)
		else $error("zero w result carries nonzero data");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");
	a_back_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_x) && $stable(zero_w))
		else $error("stalled result changed");
endmodule
